/* hw/rtl/l2lfd_pkg.sv */
`default_nettype none

package l2lfd_pkg;

  // Switch geometry.
  localparam int NUM_PORTS   = 8;
  localparam int TABLE_DEPTH = 16;

  // Derived widths.
  localparam int PORT_W   = $clog2(NUM_PORTS);
  localparam int IDX_W    = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int SPORT_W  = 4;
  localparam int MAC_W    = 48;
  localparam int ETH_W    = 16;
  localparam int MASK_W   = 8;
  localparam int STATUS_W = 3;

  // Accepted ethertypes and the broadcast address.
  localparam logic [ETH_W-1:0] ET_IPV4 = 16'h0800;
  localparam logic [ETH_W-1:0] ET_ARP  = 16'h0806;
  localparam logic [ETH_W-1:0] ET_IPV6 = 16'h86DD;
  localparam logic [ETH_W-1:0] ET_VLAN = 16'h8100;
  localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_UNICAST   = 3'd0,
    ST_BCAST     = 3'd1,
    ST_FLOOD     = 3'd2,
    ST_PORT_DROP = 3'd3,
    ST_TYPE_DROP = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic src_cmp;
    logic learn;
    logic dst_cmp;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/l2lfd_in_if.sv */
`default_nettype none

interface l2lfd_in_if;
  logic                            valid;
  logic                            ready;
  logic [l2lfd_pkg::SPORT_W-1:0]   source_port;
  logic [l2lfd_pkg::MAC_W-1:0]     src_mac;
  logic [l2lfd_pkg::MAC_W-1:0]     dst_mac;
  logic [l2lfd_pkg::ETH_W-1:0]     ether_type;

  modport source (output valid, source_port, src_mac, dst_mac, ether_type, input ready);
  modport sink   (input valid, source_port, src_mac, dst_mac, ether_type, output ready);
endinterface

`default_nettype wire

/* hw/rtl/l2lfd_out_if.sv */
`default_nettype none

interface l2lfd_out_if;
  logic                             valid;
  logic                             ready;
  logic [l2lfd_pkg::MASK_W-1:0]     forward_mask;
  logic [l2lfd_pkg::STATUS_W-1:0]   status;

  modport source (output valid, forward_mask, status, input ready);
  modport sink   (input valid, forward_mask, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/l2_learning_forward_decision.sv */
`default_nettype none

// Channel   Dir  Payload                                        Handshake
// in_ch     in   source_port, src_mac, dst_mac, ether_type      valid/ready
// out_ch    out  forward_mask, status                           valid/ready
//
// A header beat is taken only when the block is idle. After acceptance a
// forwarded frame passes source compare, learn shift, destination compare and
// decision before its result is valid; a dropped frame skips from the source
// compare state straight to the decision. The next header is accepted in the
// cycle after the result is loaded, while that result may still wait in the
// output register. A stalled output holds the decision stage until the
// register frees. Reset clears the table fill count and the sequencer.

module l2_learning_forward_decision (
  input  wire logic  clk,
  input  wire logic  rst_n,
  l2lfd_in_if.sink   in_ch,
  l2lfd_out_if.source out_ch
);

  l2lfd_pkg::cmd_t cmd;
  l2lfd_pkg::sts_t sts;

  l2lfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  l2lfd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_source_port   (in_ch.source_port),
    .in_src_mac       (in_ch.src_mac),
    .in_dst_mac       (in_ch.dst_mac),
    .in_ether_type    (in_ch.ether_type),
    .out_forward_mask (out_ch.forward_mask),
    .out_status       (out_ch.status)
  );

  // The sequencer issues at most one command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // An accepted beat closes the input until its decision is made.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted beat");

  // A dropped frame is sent nowhere.
  a_drop_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == l2lfd_pkg::ST_PORT_DROP ||
                      out_ch.status == l2lfd_pkg::ST_TYPE_DROP))
    |-> (out_ch.forward_mask == '0))
    else $error("dropped frame with a nonzero port mask");

  // A unicast decision names at most one egress port.
  a_unicast_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == l2lfd_pkg::ST_UNICAST)
    |-> ($countones(out_ch.forward_mask) <= 1))
    else $error("unicast decision with several egress ports");

endmodule

`default_nettype wire

/* hw/rtl/l2lfd_dpath.sv */
`default_nettype none

module l2lfd_dpath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire l2lfd_pkg::cmd_t                   cmd,
  output l2lfd_pkg::sts_t                        sts,
  input  wire logic [l2lfd_pkg::SPORT_W-1:0]     in_source_port,
  input  wire logic [l2lfd_pkg::MAC_W-1:0]       in_src_mac,
  input  wire logic [l2lfd_pkg::MAC_W-1:0]       in_dst_mac,
  input  wire logic [l2lfd_pkg::ETH_W-1:0]       in_ether_type,
  output logic [l2lfd_pkg::MASK_W-1:0]           out_forward_mask,
  output logic [l2lfd_pkg::STATUS_W-1:0]         out_status
);

  localparam int D = l2lfd_pkg::TABLE_DEPTH;

  // Latched header fields.
  logic [l2lfd_pkg::PORT_W-1:0] sport_r;
  logic [l2lfd_pkg::MAC_W-1:0]  src_r;
  logic [l2lfd_pkg::MAC_W-1:0]  dst_r;
  logic                         port_bad_r;
  logic                         type_bad_r;

  // MAC table, front entry most recent; each row moves only to its neighbor.
  logic [l2lfd_pkg::MAC_W-1:0]  mac_r  [D];
  logic [l2lfd_pkg::PORT_W-1:0] prt_r  [D];
  logic [l2lfd_pkg::CNT_W-1:0]  count_r;

  // Registered lookup results.
  logic [D-1:0]                 smatch_r;
  logic                         dhit_r;
  logic [l2lfd_pkg::PORT_W-1:0] dport_r;

  logic                         port_bad;
  logic                         type_ok;
  logic [D-1:0]                 valid_row;
  logic [D-1:0]                 smatch;
  logic [D-1:0]                 dmatch;
  logic [l2lfd_pkg::PORT_W-1:0] dport;
  logic                         shit;
  logic [l2lfd_pkg::IDX_W-1:0]  hidx;
  logic                         full;
  logic [l2lfd_pkg::IDX_W-1:0]  pos;
  logic [l2lfd_pkg::MASK_W-1:0] flood;
  logic [l2lfd_pkg::MASK_W-1:0] uni;
  logic [l2lfd_pkg::MASK_W-1:0] mask_nxt;
  l2lfd_pkg::status_t           status_nxt;

  // Header checks on the incoming beat.
  always_comb begin
    port_bad = ({1'b0, in_source_port} >= (l2lfd_pkg::SPORT_W + 1)'(l2lfd_pkg::NUM_PORTS));
    type_ok  = in_ether_type inside {l2lfd_pkg::ET_IPV4, l2lfd_pkg::ET_ARP,
                                     l2lfd_pkg::ET_IPV6, l2lfd_pkg::ET_VLAN};
  end

  assign sts.drop = port_bad_r | type_bad_r;

  // Per-row compare against the source and destination addresses.
  always_comb begin
    dport = '0;
    hidx  = '0;
    for (int i = 0; i < D; i++) begin
      valid_row[i] = (l2lfd_pkg::CNT_W'(i) < count_r);
      smatch[i]    = valid_row[i] && (mac_r[i] == src_r);
      dmatch[i]    = valid_row[i] && (mac_r[i] == dst_r);
      if (dmatch[i]) begin
        dport = dport | prt_r[i];
      end
      if (smatch_r[i]) begin
        hidx = hidx | l2lfd_pkg::IDX_W'(i);
      end
    end
  end

  // Row that ends the shift: the hit, the first free row, or the last row.
  always_comb begin
    shit = |smatch_r;
    full = (count_r == l2lfd_pkg::CNT_W'(D));
    if (shit) begin
      pos = hidx;
    end else if (full) begin
      pos = l2lfd_pkg::IDX_W'(D - 1);
    end else begin
      pos = count_r[l2lfd_pkg::IDX_W-1:0];
    end
  end

  // Decision from the lookup.
  always_comb begin
    for (int b = 0; b < l2lfd_pkg::MASK_W; b++) begin
      flood[b] = (b < l2lfd_pkg::NUM_PORTS) && (b != int'(sport_r));
      uni[b]   = (b == int'(dport_r));
    end
    if (port_bad_r) begin
      mask_nxt   = '0;
      status_nxt = l2lfd_pkg::ST_PORT_DROP;
    end else if (type_bad_r) begin
      mask_nxt   = '0;
      status_nxt = l2lfd_pkg::ST_TYPE_DROP;
    end else if (dst_r == l2lfd_pkg::BCAST_MAC) begin
      mask_nxt   = flood;
      status_nxt = l2lfd_pkg::ST_BCAST;
    end else if (dhit_r && (dport_r != sport_r)) begin
      mask_nxt   = uni;
      status_nxt = l2lfd_pkg::ST_UNICAST;
    end else begin
      mask_nxt   = flood;
      status_nxt = l2lfd_pkg::ST_FLOOD;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.learn && !shit && !full) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Payload registers and table rows.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sport_r    <= in_source_port[l2lfd_pkg::PORT_W-1:0];
      src_r      <= in_src_mac;
      dst_r      <= in_dst_mac;
      port_bad_r <= port_bad;
      type_bad_r <= !type_ok;
    end
    if (cmd.src_cmp) begin
      smatch_r <= smatch;
    end
    if (cmd.learn) begin
      for (int i = 1; i < D; i++) begin
        if (l2lfd_pkg::IDX_W'(i) <= pos) begin
          mac_r[i] <= mac_r[i-1];
          prt_r[i] <= prt_r[i-1];
        end
      end
      mac_r[0] <= src_r;
      prt_r[0] <= sport_r;
    end
    if (cmd.dst_cmp) begin
      dhit_r  <= |dmatch;
      dport_r <= dport;
    end
    if (cmd.out_load) begin
      out_forward_mask <= mask_nxt;
      out_status       <= status_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/l2lfd_ctrl.sv */
`default_nettype none

module l2lfd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire l2lfd_pkg::sts_t  sts,
  output l2lfd_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRC,
    S_LEARN,
    S_DST,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencing and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRC;
        end
      end
      S_SRC: begin
        if (sts.drop) begin
          state_nxt = S_FIN;
        end else begin
          cmd.src_cmp = 1'b1;
          state_nxt   = S_LEARN;
        end
      end
      S_LEARN: begin
        cmd.learn = 1'b1;
        state_nxt = S_DST;
      end
      S_DST: begin
        cmd.dst_cmp = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_l2_learning_forward_decision.sv */
`default_nettype none

module tb_l2_learning_forward_decision;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int POOL_SIZE    = 24;

  // One frame header and one forwarding decision.
  typedef struct packed {
    logic [l2lfd_pkg::SPORT_W-1:0] source_port;
    logic [l2lfd_pkg::MAC_W-1:0]   src_mac;
    logic [l2lfd_pkg::MAC_W-1:0]   dst_mac;
    logic [l2lfd_pkg::ETH_W-1:0]   ether_type;
  } hdr_t;

  typedef struct packed {
    logic [l2lfd_pkg::MASK_W-1:0] mask;
    l2lfd_pkg::status_t           status;
  } fwd_t;

  typedef struct {
    hdr_t hdr;
    bit   typed;
    fwd_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  l2lfd_in_if  in_ch ();
  l2lfd_out_if out_ch ();

  l2_learning_forward_decision u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // Shadow MAC table, front entry is the most recently learned station.
  logic [l2lfd_pkg::MAC_W-1:0]   fdb_mac  [l2lfd_pkg::TABLE_DEPTH];
  logic [l2lfd_pkg::SPORT_W-1:0] fdb_port [l2lfd_pkg::TABLE_DEPTH];
  int                            fdb_fill;

  fwd_t       fwd_expect_q [$];
  stim_row_t  stim_rows [$];
  logic [l2lfd_pkg::MAC_W-1:0] mac_pool [POOL_SIZE];
  int         fwd_errors = 0;
  int         cycle_cnt = 0;
  bit         quiet_link = 1'b0;

  // Scan only the valid entries, as the block does.
  function automatic int find_station(logic [l2lfd_pkg::MAC_W-1:0] mac);
    for (int i = 0; i < fdb_fill && i < l2lfd_pkg::TABLE_DEPTH; i++) begin
      if (fdb_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // Drop a bad header; else learn the source, then decide where the frame goes.
  function automatic fwd_t decide_forward(hdr_t h);
    fwd_t r;
    int hit;
    int pos;
    logic [31:0] flood;
    logic [31:0] uni;
    r.mask = '0;
    if (h.source_port >= l2lfd_pkg::NUM_PORTS) begin
      r.status = l2lfd_pkg::ST_PORT_DROP;
      return r;
    end
    if (h.ether_type != l2lfd_pkg::ET_IPV4 && h.ether_type != l2lfd_pkg::ET_ARP &&
        h.ether_type != l2lfd_pkg::ET_IPV6 && h.ether_type != l2lfd_pkg::ET_VLAN) begin
      r.status = l2lfd_pkg::ST_TYPE_DROP;
      return r;
    end
    hit = find_station(h.src_mac);
    if (hit >= 0) begin
      pos = hit;
    end else if (fdb_fill >= l2lfd_pkg::TABLE_DEPTH) begin
      pos = l2lfd_pkg::TABLE_DEPTH - 1;
    end else begin
      pos = fdb_fill;
      fdb_fill++;
    end
    for (int i = pos; i > 0; i--) begin
      fdb_mac[i]  = fdb_mac[i-1];
      fdb_port[i] = fdb_port[i-1];
    end
    fdb_mac[0]  = h.src_mac;
    fdb_port[0] = h.source_port;
    flood = ((32'd1 << l2lfd_pkg::NUM_PORTS) - 32'd1) & ~(32'd1 << h.source_port);
    if (h.dst_mac == l2lfd_pkg::BCAST_MAC) begin
      r.mask   = flood[l2lfd_pkg::MASK_W-1:0];
      r.status = l2lfd_pkg::ST_BCAST;
      return r;
    end
    hit = find_station(h.dst_mac);
    if (hit >= 0 && fdb_port[hit] != h.source_port) begin
      uni      = 32'd1 << fdb_port[hit];
      r.mask   = uni[l2lfd_pkg::MASK_W-1:0];
      r.status = l2lfd_pkg::ST_UNICAST;
    end else begin
      r.mask   = flood[l2lfd_pkg::MASK_W-1:0];
      r.status = l2lfd_pkg::ST_FLOOD;
    end
    return r;
  endfunction

  function automatic logic [l2lfd_pkg::MAC_W-1:0] rand_mac();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[l2lfd_pkg::MAC_W-1:0];
  endfunction

  // Mostly short gaps, a few long ones, none while the link is quiet.
  function automatic int pick_gap();
    int r;
    if (quiet_link) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_row(input logic [l2lfd_pkg::SPORT_W-1:0] port,
                         input logic [l2lfd_pkg::MAC_W-1:0] src,
                         input logic [l2lfd_pkg::MAC_W-1:0] dst,
                         input logic [l2lfd_pkg::ETH_W-1:0] et,
                         input bit typed, input logic [l2lfd_pkg::MASK_W-1:0] mask,
                         input l2lfd_pkg::status_t st);
    stim_row_t row;
    row.hdr.source_port = port;
    row.hdr.src_mac     = src;
    row.hdr.dst_mac     = dst;
    row.hdr.ether_type  = et;
    row.typed           = typed;
    row.res.mask        = mask;
    row.res.status      = st;
    stim_rows.push_back(row);
  endtask

  // Drive one header beat; entered and left at a falling edge.
  task automatic send_header(input hdr_t h, input bit typed, input fwd_t typed_res);
    int gap;
    fwd_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.source_port = h.source_port;
    in_ch.src_mac     = h.src_mac;
    in_ch.dst_mac     = h.dst_mac;
    in_ch.ether_type  = h.ether_type;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = decide_forward(h);
    fwd_expect_q.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Result side back-pressure, changed at the falling edge.
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (quiet_link) begin
        out_ch.ready = 1'b1;
        hold = $urandom_range(1, 20);
      end else begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready = 1'b1;
          hold = $urandom_range(0, 7);
        end else if (r < 95) begin
          out_ch.ready = 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_ch.ready = 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  // Compare each result beat with the oldest pending decision.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (fwd_expect_q.size() == 0) begin
        $display("%0t: result expected none actual mask=%02h status=%0d", $time,
                 out_ch.forward_mask, out_ch.status);
        fwd_errors++;
      end else begin
        fwd_t exp_res;
        exp_res = fwd_expect_q.pop_front();
        if (out_ch.forward_mask !== exp_res.mask) begin
          $display("%0t: forward_mask expected %02h actual %02h", $time,
                   exp_res.mask, out_ch.forward_mask);
          fwd_errors++;
        end
        if (out_ch.status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_res.status, out_ch.status);
          fwd_errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [l2lfd_pkg::MAC_W-1:0] mac_a, mac_b, mac_c, mac_d, mac_e;
    hdr_t h;
    fwd_t none;
    int r;

    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.source_port = '0;
    in_ch.src_mac     = '0;
    in_ch.dst_mac     = '0;
    in_ch.ether_type  = '0;
    fdb_fill          = 0;
    none              = '{mask: '0, status: l2lfd_pkg::ST_UNICAST};

    mac_a = 48'h00_11_22_33_44_55;
    mac_b = 48'h02_00_5E_10_00_01;
    mac_c = 48'hA4_B1_C2_D3_E4_F5;
    mac_d = 48'h7E_00_00_00_00_0D;
    mac_e = 48'h10_20_30_40_50_60;

    // Drops come first so that nothing has been learned yet.
    add_row(4'd8,  mac_a, l2lfd_pkg::BCAST_MAC, l2lfd_pkg::ET_IPV4, 1, 8'h00,
            l2lfd_pkg::ST_PORT_DROP);
    add_row(4'd15, mac_a, mac_b, l2lfd_pkg::ET_ARP, 1, 8'h00, l2lfd_pkg::ST_PORT_DROP);
    add_row(4'd0,  mac_a, mac_b, 16'h0000, 1, 8'h00, l2lfd_pkg::ST_TYPE_DROP);
    add_row(4'd7,  mac_a, mac_b, 16'hFFFF, 1, 8'h00, l2lfd_pkg::ST_TYPE_DROP);
    add_row(4'd3,  mac_a, mac_b, 16'h0801, 1, 8'h00, l2lfd_pkg::ST_TYPE_DROP);
    // Broadcast, unknown destination, then a known one.
    add_row(4'd0, mac_a, l2lfd_pkg::BCAST_MAC, l2lfd_pkg::ET_IPV4, 1, 8'hFE,
            l2lfd_pkg::ST_BCAST);
    add_row(4'd7, mac_b, mac_c, l2lfd_pkg::ET_ARP,  1, 8'h7F, l2lfd_pkg::ST_FLOOD);
    add_row(4'd3, mac_c, mac_a, l2lfd_pkg::ET_IPV6, 1, 8'h01, l2lfd_pkg::ST_UNICAST);
    // Source equals destination, and a destination on the ingress port.
    add_row(4'd5, mac_d, mac_d, l2lfd_pkg::ET_VLAN, 1, 8'hDF, l2lfd_pkg::ST_FLOOD);
    add_row(4'd0, mac_e, mac_a, l2lfd_pkg::ET_IPV4, 1, 8'hFE, l2lfd_pkg::ST_FLOOD);
    // A station moves to another port.
    add_row(4'd6, mac_a, mac_c, l2lfd_pkg::ET_IPV4, 0, 8'h00, l2lfd_pkg::ST_UNICAST);
    add_row(4'd2, mac_c, mac_a, l2lfd_pkg::ET_ARP,  0, 8'h00, l2lfd_pkg::ST_UNICAST);
    // Address extremes.
    add_row(4'd1, 48'h0, 48'h0, l2lfd_pkg::ET_VLAN, 0, 8'h00, l2lfd_pkg::ST_UNICAST);
    add_row(4'd4, l2lfd_pkg::BCAST_MAC, 48'h0, l2lfd_pkg::ET_IPV6, 0, 8'h00,
            l2lfd_pkg::ST_UNICAST);
    add_row(4'd7, 48'h0, l2lfd_pkg::BCAST_MAC, l2lfd_pkg::ET_IPV4, 0, 8'h00,
            l2lfd_pkg::ST_UNICAST);
    add_row(4'd1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, l2lfd_pkg::ET_ARP, 0, 8'h00,
            l2lfd_pkg::ST_UNICAST);
    add_row(4'd2, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, l2lfd_pkg::ET_ARP, 0, 8'h00,
            l2lfd_pkg::ST_UNICAST);

    for (int i = 0; i < POOL_SIZE; i++) mac_pool[i] = rand_mac();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) send_header(stim_rows[i].hdr, stim_rows[i].typed, stim_rows[i].res);

    // Random traffic over a station pool larger than the table, so entries age out.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) quiet_link = ($urandom_range(0, 9) < 3);
      if ($urandom_range(0, 49) == 0) mac_pool[$urandom_range(0, POOL_SIZE-1)] = rand_mac();

      if ($urandom_range(0, 99) < 88 || l2lfd_pkg::NUM_PORTS >= 16)
        h.source_port = l2lfd_pkg::SPORT_W'($urandom_range(0, l2lfd_pkg::NUM_PORTS-1));
      else
        h.source_port = l2lfd_pkg::SPORT_W'($urandom_range(l2lfd_pkg::NUM_PORTS, 15));

      h.src_mac = ($urandom_range(0, 99) < 85) ? mac_pool[$urandom_range(0, POOL_SIZE-1)]
                                               : rand_mac();
      r = $urandom_range(0, 99);
      if (r < 10)      h.dst_mac = l2lfd_pkg::BCAST_MAC;
      else if (r < 75) h.dst_mac = mac_pool[$urandom_range(0, POOL_SIZE-1)];
      else if (r < 85) h.dst_mac = h.src_mac;
      else             h.dst_mac = rand_mac();

      r = $urandom_range(0, 99);
      if (r < 22)      h.ether_type = l2lfd_pkg::ET_IPV4;
      else if (r < 43) h.ether_type = l2lfd_pkg::ET_ARP;
      else if (r < 64) h.ether_type = l2lfd_pkg::ET_IPV6;
      else if (r < 85) h.ether_type = l2lfd_pkg::ET_VLAN;
      else             h.ether_type = l2lfd_pkg::ETH_W'($urandom());

      send_header(h, 1'b0, none);
    end
    in_ch.valid = 1'b0;

    // Drain, then keep watching for any stray beat before the verdict.
    while (fwd_expect_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (fwd_errors == 0 && fwd_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
